@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dlle_pkg.sv @@
package dlle_pkg;

  localparam int unsigned TABLE_MAX  = 4095;
  localparam int unsigned MAX_LEVELS = 4;
  localparam int unsigned LEVEL_REGS = 4;

  localparam int unsigned LVL_IDX_W = $clog2(LEVEL_REGS);
  localparam int unsigned CFG_IDX_W = $clog2(LEVEL_REGS + 1);
  localparam int unsigned CNT_REG_W = 3;
  localparam int unsigned LVL_W     = 17;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned Q_FRAC    = 16;
  localparam int unsigned ERR_W     = 17;
  localparam int unsigned TBL_W     = $clog2(TABLE_MAX + 1);
  localparam int unsigned IDX_W     = 12;

  localparam int unsigned IPROD_W    = TBL_W + SCALE_W;
  localparam int unsigned SL_W       = SCALE_W + LVL_W;
  localparam int unsigned NUM_W      = SL_W + 1;
  localparam int unsigned SUM_W      = LVL_W + 1;
  localparam int unsigned BND_PROD_W = SCALE_W + SUM_W;
  localparam int unsigned MUL_STEPS  = 2 * LEVEL_REGS - 1;

  localparam int          ERR_MIN    = -(1 << (ERR_W - 1));

  localparam longint unsigned SCALE_MAX = (64'd1 << SCALE_W) - 64'd1;
  localparam longint unsigned Q_ONE_M1  = (64'd1 << Q_FRAC) - 64'd1;

  localparam longint unsigned DIVIDEND = longint'(TABLE_MAX) << Q_FRAC;
  localparam int unsigned     DIV_W    = $clog2(DIVIDEND + 64'd1);
  localparam int unsigned     CNT_W    = $clog2(DIV_W);

  localparam int unsigned     RECIP_L  = $clog2(TABLE_MAX);
  localparam int unsigned     RECIP_S  = IPROD_W + RECIP_L;
  localparam int unsigned     RECIP_W  = IPROD_W + 1;
  localparam int unsigned     RECIP_PW = IPROD_W + RECIP_W;
  localparam longint unsigned RECIP_M  =
    ((64'd1 << RECIP_S) + longint'(TABLE_MAX) - 64'd1) / longint'(TABLE_MAX);

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FIRST = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LAST  = CFG_IDX_W'(LEVEL_REGS);

  typedef enum logic [2:0] {
    SEQ_START,
    SEQ_DIV,
    SEQ_SCALE,
    SEQ_MUL,
    SEQ_SEG,
    SEQ_IDLE
  } seq_state_e;

endpackage

@@ hdl/dither_level_lut_entry_top.sv @@
// An accepted input word reaches the output through the four-stage lookup pipeline.
// Throughput: one word per cycle, held back by out_ready_i and by table setup.
// After reset and after every configuration write, the table setup sequencer
// (a 28-step restoring divider for the scale, then 7 multiplier steps) keeps
// in_ready_o low until idle. Reset is asynchronous, active low, and loads the
// default levels and clears all valid bits.
module dither_level_lut_entry_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dlle_pkg::IDX_W-1:0]       table_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dlle_pkg::SCALE_W-1:0]     scaled_intensity_o,
  output logic [dlle_pkg::LVL_IDX_W-1:0]   pixel_value_o,
  output logic signed [dlle_pkg::ERR_W-1:0] dither_error_o,
  output logic                             table_invalid_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dlle_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dlle_pkg::LVL_W-1:0]       cfg_data_i
);
  import dlle_pkg::*;

  localparam logic [DIV_W-1:0]   DIVIDEND_BITS = DIV_W'(DIVIDEND);
  localparam logic [RECIP_W-1:0] RECIP_MV      = RECIP_W'(RECIP_M);
  localparam logic signed [NUM_W-1:0] ERR_FLOOR = NUM_W'(ERR_MIN);

  logic                 cfg_we;
  logic [CNT_REG_W-1:0] level_count_q;
  logic [LVL_W-1:0]     level_q [LEVEL_REGS];
  logic [CNT_REG_W-1:0] n_eff;
  logic [LVL_W-1:0]     last_lvl;

  seq_state_e state_q, state_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [LVL_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quot_q, quot_d;
  logic [LVL_W:0]       rem_sh;
  logic                 div_ge;
  logic [SCALE_W-1:0]   scale_q, scale_sat;
  logic                 inv_q;
  logic [LVL_IDX_W-1:0] bidx;
  logic [SUM_W-1:0]     mul_b;
  logic [BND_PROD_W-1:0] mul_p;
  logic [TBL_W-1:0]     bnd_clamp;
  logic [SL_W-1:0]      sl_q [LEVEL_REGS];
  logic [TBL_W-1:0]     bnd_q [LEVEL_REGS-1];
  logic [TBL_W-1:0]     seg_start_d [LEVEL_REGS];
  logic [TBL_W-1:0]     seg_end_d [LEVEL_REGS];
  logic [LEVEL_REGS-1:0] seg_live_d;
  logic [TBL_W-1:0]     seg_start_q [LEVEL_REGS];
  logic [TBL_W-1:0]     seg_end_q [LEVEL_REGS];
  logic [LEVEL_REGS-1:0] seg_live_q;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_q, v2_q, v3_q, v4_q;
  logic [TBL_W-1:0]     idx_in, idx1_q, idx2_q;
  logic [LVL_IDX_W-1:0] pix_d, pix2_q, pix3_q, pix4_q;
  logic                 cov_d, cov2_q, errok3_q;
  logic [IPROD_W-1:0]   iprod_d, iprod2_q;
  logic [RECIP_PW-1:0]  recip_p;
  logic signed [NUM_W-1:0] num_d, num3_q, num_adj, num_sh, num_sat;
  logic [SCALE_W-1:0]   int3_q, int4_q;
  logic signed [ERR_W-1:0] err_d, err4_q;
  logic [SCALE_W-1:0]   int_out_d;
  logic [LVL_IDX_W-1:0] pix_out_d;
  logic                 inv4_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= CNT_REG_W'(1);
      level_q[0]    <= LVL_W'(1 << Q_FRAC);
      for (int k = 1; k < LEVEL_REGS; k++) begin
        level_q[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index_i == REG_LEVEL_COUNT) begin
        level_count_q <= cfg_data_i[CNT_REG_W-1:0];
      end else if (cfg_index_i inside {[REG_LEVEL_FIRST:REG_LEVEL_LAST]}) begin
        level_q[LVL_IDX_W'(cfg_index_i - REG_LEVEL_FIRST)] <= cfg_data_i;
      end
    end
  end

  always_comb begin
    n_eff = level_count_q;
    if (n_eff > CNT_REG_W'(MAX_LEVELS)) begin
      n_eff = CNT_REG_W'(MAX_LEVELS);
    end
    if (n_eff > CNT_REG_W'(LEVEL_REGS)) begin
      n_eff = CNT_REG_W'(LEVEL_REGS);
    end
  end

  assign last_lvl = level_q[LVL_IDX_W'(n_eff - 1'b1)];

  // Restoring divider for the scale, one quotient bit per cycle.
  assign rem_sh = {rem_q, DIVIDEND_BITS[cnt_q]};
  assign div_ge = rem_sh >= {1'b0, last_lvl};
  assign rem_d  = div_ge ? LVL_W'(rem_sh - {1'b0, last_lvl}) : rem_sh[LVL_W-1:0];
  assign quot_d = {quot_q[DIV_W-2:0], div_ge};
  assign scale_sat = (64'(quot_q) > SCALE_MAX) ? SCALE_W'(SCALE_MAX) : quot_q[SCALE_W-1:0];

  // Shared multiplier: scaled levels first, then the segment boundaries.
  assign bidx = LVL_IDX_W'(cnt_q - CNT_W'(LEVEL_REGS));

  always_comb begin
    if (cnt_q < CNT_W'(LEVEL_REGS)) begin
      mul_b = SUM_W'(level_q[cnt_q[LVL_IDX_W-1:0]]);
    end else begin
      mul_b = SUM_W'(level_q[bidx]) + SUM_W'(level_q[LVL_IDX_W'(bidx + 1'b1)]);
    end
  end

  assign mul_p = BND_PROD_W'(scale_q) * BND_PROD_W'(mul_b);
  assign bnd_clamp = (mul_p[BND_PROD_W-1:Q_FRAC+1] > (BND_PROD_W-Q_FRAC-1)'(TABLE_MAX)) ?
                     TBL_W'(TABLE_MAX) : TBL_W'(mul_p[BND_PROD_W-1:Q_FRAC+1]);

  always_comb begin
    logic                alive;
    logic [TBL_W:0]      stw;
    logic [TBL_W-1:0]    st;
    logic [TBL_W-1:0]    en;
    int                  bi_prev;
    int                  bi_cur;
    alive = 1'b1;
    for (int p = 0; p < LEVEL_REGS; p++) begin
      bi_prev = (p > 0) ? p - 1 : 0;
      bi_cur  = (p < LEVEL_REGS - 1) ? p : 0;
      stw = (TBL_W+1)'(bnd_q[bi_prev]) + (TBL_W+1)'(1);
      if (p == 0) begin
        st = '0;
      end else if (stw > (TBL_W+1)'(TABLE_MAX)) begin
        st = TBL_W'(TABLE_MAX);
      end else begin
        st = stw[TBL_W-1:0];
      end
      if ((p == int'(n_eff) - 1) || (p == LEVEL_REGS - 1)) begin
        en = TBL_W'(TABLE_MAX);
      end else begin
        en = bnd_q[bi_cur];
      end
      alive = alive && (p < int'(n_eff)) && (st != en);
      seg_start_d[p] = st;
      seg_end_d[p]   = en;
      seg_live_d[p]  = alive;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_START;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_START: state_d = SEQ_DIV;
      SEQ_DIV: begin
        if (cnt_q == '0) begin
          state_d = SEQ_SCALE;
        end
      end
      SEQ_SCALE: state_d = SEQ_MUL;
      SEQ_MUL: begin
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          state_d = SEQ_SEG;
        end
      end
      SEQ_SEG:  state_d = SEQ_IDLE;
      SEQ_IDLE: state_d = SEQ_IDLE;
      default:  state_d = SEQ_START;
    endcase
    if (cfg_we) begin
      state_d = SEQ_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      inv_q <= 1'b0;
    end else begin
      case (state_q)
        SEQ_START: begin
          cnt_q <= CNT_W'(DIV_W - 1);
          inv_q <= (n_eff == '0) || (last_lvl == '0);
        end
        SEQ_DIV: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        SEQ_SCALE: cnt_q <= '0;
        SEQ_MUL:   cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SEQ_START: begin
        rem_q  <= '0;
        quot_q <= '0;
      end
      SEQ_DIV: begin
        rem_q  <= rem_d;
        quot_q <= quot_d;
      end
      SEQ_SCALE: scale_q <= scale_sat;
      SEQ_MUL: begin
        if (cnt_q < CNT_W'(LEVEL_REGS)) begin
          sl_q[cnt_q[LVL_IDX_W-1:0]] <= mul_p[SL_W-1:0];
        end else begin
          bnd_q[bidx] <= bnd_clamp;
        end
      end
      SEQ_SEG: begin
        seg_start_q <= seg_start_d;
        seg_end_q   <= seg_end_d;
        seg_live_q  <= seg_live_d;
      end
      default: ;
    endcase
  end

  // Lookup pipeline.
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1 && (state_q == SEQ_IDLE);

  assign idx_in = (table_index_i > IDX_W'(TABLE_MAX)) ? TBL_W'(TABLE_MAX) :
                  TBL_W'(table_index_i);

  always_comb begin
    pix_d = '0;
    cov_d = 1'b0;
    for (int p = 0; p < LEVEL_REGS; p++) begin
      if (seg_live_q[p] && (idx1_q >= seg_start_q[p]) && (idx1_q <= seg_end_q[p])) begin
        pix_d = LVL_IDX_W'(p);
        cov_d = 1'b1;
      end
    end
  end

  assign iprod_d = IPROD_W'(idx1_q) * IPROD_W'(scale_q);
  assign recip_p = RECIP_PW'(iprod2_q) * RECIP_PW'(RECIP_MV);
  assign num_d   = $signed(NUM_W'({idx2_q, {Q_FRAC{1'b0}}})) - $signed(NUM_W'(sl_q[pix2_q]));
  assign num_adj = num3_q + $signed(NUM_W'(Q_ONE_M1));
  assign num_sh  = (num3_q < 0) ? (num_adj >>> Q_FRAC) : (num3_q >>> Q_FRAC);
  assign num_sat = (num_sh < ERR_FLOOR) ? ERR_FLOOR : num_sh;

  always_comb begin
    err_d     = errok3_q ? ERR_W'(num_sat) : '0;
    int_out_d = int3_q;
    pix_out_d = pix3_q;
    if (inv_q) begin
      err_d     = '0;
      int_out_d = '0;
      pix_out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i && in_ready_o;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      idx1_q <= idx_in;
    end
    if (rdy2) begin
      idx2_q   <= idx1_q;
      pix2_q   <= pix_d;
      cov2_q   <= cov_d;
      iprod2_q <= iprod_d;
    end
    if (rdy3) begin
      int3_q   <= recip_p[RECIP_S +: SCALE_W];
      num3_q   <= num_d;
      pix3_q   <= pix2_q;
      errok3_q <= cov2_q && (idx2_q != '0);
    end
    if (rdy4) begin
      int4_q <= int_out_d;
      pix4_q <= pix_out_d;
      err4_q <= err_d;
      inv4_q <= inv_q;
    end
  end

  assign out_valid_o        = v4_q;
  assign scaled_intensity_o = int4_q;
  assign pixel_value_o      = pix4_q;
  assign dither_error_o     = err4_q;
  assign table_invalid_o    = inv4_q;

endmodule

@@ hdl/dlle_chk.sv @@
`include "assert_macros.svh"

module dlle_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [dlle_pkg::IDX_W-1:0]        table_index_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [dlle_pkg::SCALE_W-1:0]      scaled_intensity_o,
  input logic [dlle_pkg::LVL_IDX_W-1:0]    pixel_value_o,
  input logic signed [dlle_pkg::ERR_W-1:0] dither_error_o,
  input logic                              table_invalid_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [dlle_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input logic [dlle_pkg::LVL_W-1:0]        cfg_data_i
);
  import dlle_pkg::*;

  logic in_seen;
  logic cfg_seen;

  assign in_seen  = in_valid_i || (table_index_i != '0);
  assign cfg_seen = (cfg_index_i != '0) || (cfg_data_i != '0) || in_seen;

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(scaled_intensity_o) && $stable(pixel_value_o) && $stable(dither_error_o) && $stable(table_invalid_o), "Stalled output word changed")
  `ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, out_valid_o && table_invalid_o, (scaled_intensity_o == '0) && (pixel_value_o == '0) && (dither_error_o == '0), "Invalid table word carries nonzero fields")
  `ASSERT_IMP(a_err_range, clk_i, rst_ni, out_valid_o, (dither_error_o <= $signed(ERR_W'(TABLE_MAX))), "Dither error out of range")
  `ASSERT_NXT(a_cfg_rebuild, clk_i, rst_ni, cfg_valid_i && cfg_ready_o && (cfg_seen || !cfg_seen), !in_ready_o, "Input accepted while the table is rebuilt")

endmodule

bind dither_level_lut_entry_top dlle_chk u_dlle_chk (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import dlle_pkg::*;

  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PIPE_SLACK = 8;

  typedef struct {
    logic [SCALE_W-1:0]      intensity;
    logic [LVL_IDX_W-1:0]    pixel;
    logic signed [ERR_W-1:0] error;
    logic                    invalid;
  } entry_t;

  class lut_entry_board;
    logic [CNT_REG_W-1:0] level_count;
    logic [LVL_W-1:0]     levels [LEVEL_REGS];
    entry_t               pending_entries [$];
    int                   fails;

    function new();
      level_count = CNT_REG_W'(1);
      levels[0] = LVL_W'(65536);
      for (int i = 1; i < LEVEL_REGS; i++) levels[i] = '0;
      fails = 0;
    endfunction

    function void report(string msg);
      fails++;
      if (fails <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LVL_W-1:0] data);
      if (idx == REG_LEVEL_COUNT) level_count = data[CNT_REG_W-1:0];
      else if (idx >= REG_LEVEL_FIRST && idx <= REG_LEVEL_LAST) levels[idx - REG_LEVEL_FIRST] = data;
    endfunction

    function int levels_in_use();
      int n;
      n = level_count;
      if (n > MAX_LEVELS) n = MAX_LEVELS;
      if (n > LEVEL_REGS) n = LEVEL_REGS;
      return n;
    endfunction

    // Zero stands for a table that cannot be built.
    function longint unsigned table_scale();
      longint unsigned last, s;
      int n;
      n = levels_in_use();
      if (n == 0) return 0;
      last = levels[n-1];
      if (last == 0) return 0;
      s = (longint'(TABLE_MAX) << Q_FRAC) / last;
      if (s > SCALE_MAX) s = SCALE_MAX;
      return s;
    endfunction

    function entry_t lookup(logic [IDX_W-1:0] idx_in);
      longint unsigned idx, s, seg_start, seg_end, pix;
      longint num, err;
      int n;
      bit covered;
      entry_t r;
      r.intensity = '0;
      r.pixel = '0;
      r.error = '0;
      r.invalid = 1'b1;
      idx = idx_in;
      if (idx > TABLE_MAX) idx = TABLE_MAX;
      n = levels_in_use();
      s = table_scale();
      if (s == 0) return r;
      pix = 0;
      covered = 1'b0;
      err = 0;
      for (int p = 0; p < n; p++) begin
        if (p == 0) seg_start = 0;
        else seg_start = s * (levels[p-1] + levels[p]) / (2 * (Q_ONE_M1 + 1)) + 1;
        if (seg_start > TABLE_MAX) seg_start = TABLE_MAX;
        if (p == n - 1) seg_end = TABLE_MAX;
        else seg_end = s * (levels[p] + levels[p+1]) / (2 * (Q_ONE_M1 + 1));
        if (seg_end > TABLE_MAX) seg_end = TABLE_MAX;
        if (seg_start == seg_end) break;
        if (idx >= seg_start && idx <= seg_end) begin
          pix = p;
          covered = 1'b1;
        end
      end
      if (covered && idx != 0) begin
        num = longint'(idx << Q_FRAC) - longint'(s * levels[pix]);
        err = num / longint'(Q_ONE_M1 + 1);
        if (err < -65536) err = -65536;
        if (err > 65535) err = 65535;
      end
      r.intensity = SCALE_W'(idx * s / TABLE_MAX);
      r.pixel = LVL_IDX_W'(pix);
      r.error = ERR_W'(err);
      r.invalid = 1'b0;
      return r;
    endfunction

    function void note_index(logic [IDX_W-1:0] idx);
      pending_entries.push_back(lookup(idx));
    endfunction

    function void check_entry(logic [SCALE_W-1:0] intensity, logic [LVL_IDX_W-1:0] pixel,
                              logic signed [ERR_W-1:0] error, logic invalid);
      entry_t e;
      if (pending_entries.size() == 0) begin
        report("result word arrived with nothing expected");
        return;
      end
      e = pending_entries.pop_front();
      if (intensity !== e.intensity)
        report($sformatf("scaled_intensity %0d, expected %0d", intensity, e.intensity));
      if (pixel !== e.pixel)
        report($sformatf("pixel_value %0d, expected %0d", pixel, e.pixel));
      if (error !== e.error)
        report($sformatf("dither_error %0d, expected %0d", error, e.error));
      if (invalid !== e.invalid)
        report($sformatf("table_invalid %0b, expected %0b", invalid, e.invalid));
    endfunction

    function int waiting();
      return pending_entries.size();
    endfunction

    // Mostly uniform, with a share of indexes near segment edges and table ends.
    function logic [IDX_W-1:0] pick_index();
      longint unsigned s, b;
      int p;
      case ($urandom_range(0, 9))
        0: return '0;
        1: return IDX_W'(TABLE_MAX);
        2, 3, 4: begin
          s = table_scale();
          p = $urandom_range(0, LEVEL_REGS - 2);
          b = s * (levels[p] + levels[p+1]) / (2 * (Q_ONE_M1 + 1)) + $urandom_range(0, 2);
          if (b > 0) b = b - 1;
          if (b > TABLE_MAX) b = TABLE_MAX;
          return IDX_W'(b);
        end
        default: return IDX_W'($urandom_range(0, TABLE_MAX));
      endcase
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [IDX_W-1:0] table_index = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LVL_W-1:0] cfg_data = '0;

  logic in_ready;
  logic out_valid;
  logic [SCALE_W-1:0] scaled_intensity;
  logic [LVL_IDX_W-1:0] pixel_value;
  logic signed [ERR_W-1:0] dither_error;
  logic table_invalid;
  logic cfg_ready;

  lut_entry_board board;
  int unsigned cycles = 0;
  int idle_pct = 0;
  bit hold_long = 1'b0;

  dither_level_lut_entry_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .table_index_i      (table_index),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .scaled_intensity_o (scaled_intensity),
    .pixel_value_o      (pixel_value),
    .dither_error_o     (dither_error),
    .table_invalid_o    (table_invalid),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("dither_level_lut_entry_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) board.note_index(table_index);
      if (out_valid && out_ready)
        board.check_entry(scaled_intensity, pixel_value, dither_error, table_invalid);
    end
  end

  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_index(input logic [IDX_W-1:0] idx);
    in_valid <= 1'b1;
    table_index <= idx;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic set_table(input logic [CNT_REG_W-1:0] cnt, input logic [LVL_W-1:0] l0,
                           input logic [LVL_W-1:0] l1, input logic [LVL_W-1:0] l2,
                           input logic [LVL_W-1:0] l3);
    logic [LVL_W-1:0] vals [LEVEL_REGS];
    vals = '{l0, l1, l2, l3};
    do @(posedge clk_i); while (board.waiting() != 0);
    repeat (PIPE_SLACK) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= REG_LEVEL_COUNT;
    cfg_data <= LVL_W'(cnt);
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    for (int i = 0; i < LEVEL_REGS; i++) begin
      cfg_index <= REG_LEVEL_FIRST + CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_case(input logic [CNT_REG_W-1:0] cnt, input logic [LVL_W-1:0] l0,
                               input logic [LVL_W-1:0] l1, input logic [LVL_W-1:0] l2,
                               input logic [LVL_W-1:0] l3);
    set_table(cnt, l0, l1, l2, l3);
    send_index(IDX_W'(1));
    send_index(board.pick_index());
    send_index(IDX_W'(TABLE_MAX - 1));
    in_valid <= 1'b0;
  endtask

  function automatic logic [LVL_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return LVL_W'(65536);
      2: return LVL_W'($urandom_range(0, 255));
      3: return LVL_W'(65535);
      default: return LVL_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic random_table();
    logic [LVL_W-1:0] v [LEVEL_REGS];
    logic [LVL_W-1:0] t;
    logic [CNT_REG_W-1:0] cnt;
    for (int i = 0; i < LEVEL_REGS; i++) v[i] = rand_level();
    if ($urandom_range(0, 9) < 7) begin
      for (int i = 0; i < LEVEL_REGS; i++)
        for (int j = 0; j < LEVEL_REGS - 1 - i; j++)
          if (v[j] > v[j+1]) begin
            t = v[j];
            v[j] = v[j+1];
            v[j+1] = t;
          end
    end
    if ($urandom_range(0, 7) == 0) cnt = CNT_REG_W'($urandom_range(0, 7));
    else cnt = CNT_REG_W'($urandom_range(1, MAX_LEVELS));
    set_table(cnt, v[0], v[1], v[2], v[3]);
  endtask

  task automatic run_items(input int count, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        in_valid <= 1'b0;
        do @(posedge clk_i); while (board.waiting() != 0);
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      send_index(board.pick_index());
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_index('0);
    send_index(IDX_W'(TABLE_MAX));
    send_index(IDX_W'(12'hAAA));
    send_index(IDX_W'(12'h555));
    in_valid <= 1'b0;

    directed_case(3'd4, 17'd0, 17'd21845, 17'd43690, 17'd65536);
    directed_case(3'd0, 17'd0, 17'd16384, 17'd32768, 17'd65536);
    directed_case(3'd3, 17'd32768, 17'd65536, 17'd0, 17'd65536);
    directed_case(3'd7, 17'd65535, 17'd1, 17'd1, 17'd1);
    directed_case(3'd2, 17'd65536, 17'd65536, 17'd0, 17'd0);
    directed_case(3'd1, 17'd1, 17'd0, 17'd0, 17'd0);
    directed_case(3'd4, 17'd0, 17'd0, 17'd0, 17'd65536);
    directed_case(3'd2, 17'd131071, 17'd1, 17'd0, 17'd0);

    for (int k = 0; k < 12; k++) begin
      random_table();
      if (k >= 10) idle_pct = 0;
      else idle_pct = 20 * $urandom_range(0, 2);
      if (k == 3) hold_long = 1'b1;
      run_items($urandom_range(70, 100), (k == 6) ? 40 : -1);
    end

    do @(posedge clk_i); while (board.waiting() != 0);
    repeat (4 * PIPE_SLACK) @(posedge clk_i);
    if (board.fails == 0) begin
      $display("dither_level_lut_entry_top regression: pass");
    end else begin
      $display("dither_level_lut_entry_top regression: fail");
    end
    $finish;
  end

endmodule
